### sv/amob_pkg.sv
// Package for the alpha map and opaque bounds block.
// Holds the shared types, register codes, reset values and result codes.
// No dependencies; every other file in this folder uses it.
package amob_pkg;

   localparam int unsigned PIXEL_W    = 32;
   localparam int unsigned MARGIN_W   = 12;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // Widest position counter that any legal image size parameter can need.
   localparam int unsigned POS_MAX_W  = 16;

   // Decoupling queue between the front and back halves.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW    = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_BITS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_POS       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_THRESHOLD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_ALPHA       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIP_BORDERS   = 3'd6;

   // Result kinds.
   localparam logic ITEM_PIXEL  = 1'b0;
   localparam logic ITEM_BOUNDS = 1'b1;

   // Register reset values.
   localparam logic [31:0] RST_ALPHA_BITS      = 32'hFF00_0000;
   localparam logic [4:0]  RST_ALPHA_POS       = 5'd24;
   localparam logic [7:0]  RST_ALPHA_THRESHOLD = 8'd20;
   localparam logic [12:0] RST_IMAGE_WIDTH     = 13'd1;
   localparam logic [12:0] RST_IMAGE_HEIGHT    = 13'd1;

   typedef struct packed {
      logic [31:0] alpha_bits;
      logic [4:0]  alpha_pos;
      logic [7:0]  alpha_threshold;
      logic [12:0] image_width;
      logic [12:0] image_height;
      logic        has_alpha;
      logic        strip_borders;
   } amob_cfg_type;

   // One classified pixel, handed from the front half to the back half.
   typedef struct packed {
      logic                 transparent;
      logic                 opaque;
      logic                 end_of_image;
      logic                 emit_end;
      logic [POS_MAX_W-1:0] column;
      logic [POS_MAX_W-1:0] row;
      logic [POS_MAX_W-1:0] width_last;
      logic [POS_MAX_W-1:0] height_last;
   } amob_entry_type;

   typedef enum logic {
      BACK_RUN,
      BACK_END
   } amob_back_state_type;

endpackage

### sv/amob_ifs.sv
// Valid/ready channel interfaces for the pixel input and the result output.
// Depends on amob_pkg for field widths.
interface amob_req_if;
   logic                         valid;
   logic                         ready;
   logic [amob_pkg::PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface amob_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          item_type;
   logic                          transparent;
   logic [amob_pkg::MARGIN_W-1:0] left_margin;
   logic [amob_pkg::MARGIN_W-1:0] top_margin;
   logic [amob_pkg::MARGIN_W-1:0] right_margin;
   logic [amob_pkg::MARGIN_W-1:0] bottom_margin;
   logic                          found;
   logic                          last;

   modport source (output valid, output item_type, output transparent,
                   output left_margin, output top_margin, output right_margin,
                   output bottom_margin, output found, output last, input ready);
   modport sink (input valid, input item_type, input transparent,
                 input left_margin, input top_margin, input right_margin,
                 input bottom_margin, input found, input last, output ready);
endinterface

### sv/amob_front.sv
// Front half: accepts pixels, counts column and row, and classifies each pixel.
// Depends on amob_pkg and amob_req_if.
module amob_front #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                    clock,
   input  logic                    reset,
   input  amob_pkg::amob_cfg_type  cfg,
   amob_req_if.sink                req,
   input  logic                    q_full,
   output logic                    q_push,
   output amob_pkg::amob_entry_type q_data
);

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] width_last;
   logic [ROW_W-1:0] height_last;
   logic [31:0]      alpha;
   logic [31:0]      threshold;
   logic             end_of_row;
   logic             end_of_image;
   logic             accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign q_push    = accept;

   // Out-of-range sizes clamp to 1 and to the maximum.
   always_comb begin
      if (cfg.image_width == '0) begin
         width_last = '0;
      end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
         width_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         width_last = COL_W'(32'(cfg.image_width) - 32'd1);
      end
      if (cfg.image_height == '0) begin
         height_last = '0;
      end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
         height_last = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         height_last = ROW_W'(32'(cfg.image_height) - 32'd1);
      end
   end

   assign alpha        = req.pixel & cfg.alpha_bits;
   assign threshold    = 32'(cfg.alpha_threshold) << cfg.alpha_pos;
   assign end_of_row   = column_ff >= width_last;
   assign end_of_image = end_of_row && (row_ff >= height_last);

   always_comb begin
      q_data.transparent  = cfg.has_alpha && (alpha == '0);
      q_data.opaque       = cfg.has_alpha && cfg.strip_borders && (alpha > threshold);
      q_data.end_of_image = end_of_image;
      q_data.emit_end     = end_of_image && cfg.strip_borders;
      q_data.column       = amob_pkg::POS_MAX_W'(column_ff);
      q_data.row          = amob_pkg::POS_MAX_W'(row_ff);
      q_data.width_last   = amob_pkg::POS_MAX_W'(width_last);
      q_data.height_last  = amob_pkg::POS_MAX_W'(height_last);
   end

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (accept) begin
         if (end_of_image) begin
            column_in = '0;
            row_in    = '0;
         end else if (end_of_row) begin
            column_in = '0;
            row_in    = row_ff + ROW_W'(1);
         end else begin
            column_in = column_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

### sv/amob_fifo.sv
// Short queue of classified pixels between the front and back halves.
// Depends on amob_pkg for the entry type and depth.
module amob_fifo (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  amob_pkg::amob_entry_type push_data,
   output logic                     full,
   input  logic                     pop,
   output logic                     valid,
   output amob_pkg::amob_entry_type pop_data
);

   localparam int unsigned AW = amob_pkg::QUEUE_AW;

   amob_pkg::amob_entry_type entries_ff [amob_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full     = count_ff == (AW+1)'(amob_pkg::QUEUE_DEPTH);
   assign valid    = count_ff != '0;
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/amob_back.sv
// Back half: tracks the opaque bounds and drives the registered result channel.
// Depends on amob_pkg and amob_rsp_if.
module amob_back #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  amob_pkg::amob_entry_type q_data,
   output logic                     q_pop,
   amob_rsp_if.source               rsp
);

   localparam int unsigned COL_W = $clog2(MAX_WIDTH);
   localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
   localparam int unsigned MW    = amob_pkg::MARGIN_W;

   amob_pkg::amob_back_state_type state_ff, state_in;

   logic [COL_W-1:0] min_col_ff, min_col_in, max_col_ff, max_col_in;
   logic [ROW_W-1:0] min_row_ff, min_row_in, max_row_ff, max_row_in;
   logic             any_ff, any_in;
   logic [COL_W-1:0] wlast_ff, wlast_in;
   logic [ROW_W-1:0] hlast_ff, hlast_in;

   logic             valid_ff, valid_in;
   logic             item_type_ff, item_type_in;
   logic             transparent_ff, transparent_in;
   logic [MW-1:0]    left_ff, left_in, top_ff, top_in;
   logic [MW-1:0]    right_ff, right_in, bottom_ff, bottom_in;
   logic             found_ff, found_in;
   logic             last_ff, last_in;

   logic             out_free;
   logic             load_pixel;
   logic             load_end;
   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;

   assign out_free = !valid_ff || rsp.ready;
   assign col      = COL_W'(q_data.column);
   assign row      = ROW_W'(q_data.row);

   always_comb begin
      case (state_ff)
         amob_pkg::BACK_RUN: begin
            if (q_valid && out_free && q_data.emit_end) begin
               state_in = amob_pkg::BACK_END;
            end else begin
               state_in = amob_pkg::BACK_RUN;
            end
         end
         amob_pkg::BACK_END: begin
            state_in = out_free ? amob_pkg::BACK_RUN : amob_pkg::BACK_END;
         end
         default: state_in = amob_pkg::BACK_RUN;
      endcase
   end

   always_comb begin
      case (state_ff)
         amob_pkg::BACK_RUN: begin
            load_pixel = q_valid && out_free;
            load_end   = 1'b0;
         end
         amob_pkg::BACK_END: begin
            load_pixel = 1'b0;
            load_end   = out_free;
         end
         default: begin
            load_pixel = 1'b0;
            load_end   = 1'b0;
         end
      endcase
   end

   assign q_pop = load_pixel;

   // Bounds: the end result is built in BACK_END after the last pixel, from the
   // registered bounds that already include that pixel.
   always_comb begin
      min_col_in = min_col_ff;
      max_col_in = max_col_ff;
      min_row_in = min_row_ff;
      max_row_in = max_row_ff;
      any_in     = any_ff;
      wlast_in   = wlast_ff;
      hlast_in   = hlast_ff;
      if (load_pixel) begin
         wlast_in = COL_W'(q_data.width_last);
         hlast_in = ROW_W'(q_data.height_last);
         if (q_data.end_of_image && !q_data.emit_end) begin
            min_col_in = '1;
            max_col_in = '0;
            min_row_in = '1;
            max_row_in = '0;
            any_in     = 1'b0;
         end else if (q_data.opaque) begin
            min_col_in = (col < min_col_ff) ? col : min_col_ff;
            max_col_in = (col > max_col_ff) ? col : max_col_ff;
            min_row_in = (row < min_row_ff) ? row : min_row_ff;
            max_row_in = (row > max_row_ff) ? row : max_row_ff;
            any_in     = 1'b1;
         end
      end else if (load_end) begin
         min_col_in = '1;
         max_col_in = '0;
         min_row_in = '1;
         max_row_in = '0;
         any_in     = 1'b0;
      end
   end

   always_comb begin
      valid_in       = valid_ff;
      item_type_in   = item_type_ff;
      transparent_in = transparent_ff;
      left_in        = left_ff;
      top_in         = top_ff;
      right_in       = right_ff;
      bottom_in      = bottom_ff;
      found_in       = found_ff;
      last_in        = last_ff;
      if (out_free) begin
         valid_in = 1'b0;
      end
      if (load_pixel) begin
         valid_in       = 1'b1;
         item_type_in   = amob_pkg::ITEM_PIXEL;
         transparent_in = q_data.transparent;
         left_in        = '0;
         top_in         = '0;
         right_in       = '0;
         bottom_in      = '0;
         found_in       = 1'b0;
         last_in        = !q_data.emit_end;
      end else if (load_end) begin
         valid_in       = 1'b1;
         item_type_in   = amob_pkg::ITEM_BOUNDS;
         transparent_in = 1'b0;
         left_in        = '0;
         top_in         = '0;
         right_in       = '0;
         bottom_in      = '0;
         found_in       = any_ff;
         last_in        = 1'b1;
         if (any_ff) begin
            left_in = MW'(min_col_ff);
            top_in  = MW'(min_row_ff);
            // Bounds left over from a larger image saturate to zero.
            if (max_col_ff <= wlast_ff) begin
               right_in = MW'(wlast_ff - max_col_ff);
            end
            if (max_row_ff <= hlast_ff) begin
               bottom_in = MW'(hlast_ff - max_row_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= amob_pkg::BACK_RUN;
         valid_ff   <= 1'b0;
         min_col_ff <= '1;
         max_col_ff <= '0;
         min_row_ff <= '1;
         max_row_ff <= '0;
         any_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         min_col_ff <= min_col_in;
         max_col_ff <= max_col_in;
         min_row_ff <= min_row_in;
         max_row_ff <= max_row_in;
         any_ff     <= any_in;
      end
   end

   always_ff @(posedge clock) begin
      wlast_ff       <= wlast_in;
      hlast_ff       <= hlast_in;
      item_type_ff   <= item_type_in;
      transparent_ff <= transparent_in;
      left_ff        <= left_in;
      top_ff         <= top_in;
      right_ff       <= right_in;
      bottom_ff      <= bottom_in;
      found_ff       <= found_in;
      last_ff        <= last_in;
   end

   assign rsp.valid         = valid_ff;
   assign rsp.item_type     = item_type_ff;
   assign rsp.transparent   = transparent_ff;
   assign rsp.left_margin   = left_ff;
   assign rsp.top_margin    = top_ff;
   assign rsp.right_margin  = right_ff;
   assign rsp.bottom_margin = bottom_ff;
   assign rsp.found         = found_ff;
   assign rsp.last          = last_ff;

endmodule

### sv/alpha_map_and_opaque_bounds_top.sv
// Top level of the alpha map and opaque bounds block: registers, front, queue, back.
// Depends on amob_pkg, amob_ifs, amob_front, amob_fifo and amob_back.
//
//   channel   direction  transfer carries
//   req_chan  in         one 32-bit pixel word, raster order
//   rsp_chan  out        pixel flag, or end-of-image margins and found flag
//   csr_*     in         register write: enable, index, data (no read-back)
//
// Flow: one pixel is accepted every clock while the queue is not full. Each pixel
// yields one flag result, which passes through the queue and then the result
// register. The last pixel of an image with border stripping on adds a margins
// result after its flag, built in BACK_END; the result register sets the pace.
// Reset: synchronous and active high; it restores register defaults, clears
// the position counters, the bounds and the queue.
// Stalls: a stall on rsp_chan fills the four-entry queue before req_chan.ready
// falls; req_chan.ready depends only on the queue being full.
module alpha_map_and_opaque_bounds_top #(
   parameter int unsigned MAX_WIDTH  = 4096,
   parameter int unsigned MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   amob_req_if.sink                          req_chan,
   amob_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [amob_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [amob_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   amob_pkg::amob_cfg_type   cfg_ff, cfg_in;
   amob_pkg::amob_entry_type push_data;
   amob_pkg::amob_entry_type pop_data;
   logic                     q_push;
   logic                     q_full;
   logic                     q_pop;
   logic                     q_valid;

   // Register file. Writes are to be made only while the block is idle; the block
   // itself does not enforce it. A pixel sees the values that held when accepted.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            amob_pkg::CSR_ALPHA_BITS:      cfg_in.alpha_bits      = csr_wdata;
            amob_pkg::CSR_ALPHA_POS:       cfg_in.alpha_pos       = csr_wdata[4:0];
            amob_pkg::CSR_ALPHA_THRESHOLD: cfg_in.alpha_threshold = csr_wdata[7:0];
            amob_pkg::CSR_IMAGE_WIDTH:     cfg_in.image_width     = csr_wdata[12:0];
            amob_pkg::CSR_IMAGE_HEIGHT:    cfg_in.image_height    = csr_wdata[12:0];
            amob_pkg::CSR_HAS_ALPHA:       cfg_in.has_alpha       = csr_wdata[0];
            amob_pkg::CSR_STRIP_BORDERS:   cfg_in.strip_borders   = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha_bits      <= amob_pkg::RST_ALPHA_BITS;
         cfg_ff.alpha_pos       <= amob_pkg::RST_ALPHA_POS;
         cfg_ff.alpha_threshold <= amob_pkg::RST_ALPHA_THRESHOLD;
         cfg_ff.image_width     <= amob_pkg::RST_IMAGE_WIDTH;
         cfg_ff.image_height    <= amob_pkg::RST_IMAGE_HEIGHT;
         cfg_ff.has_alpha       <= 1'b1;
         cfg_ff.strip_borders   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front half classifies each pixel against the current registers and
   // its own column and row count.
   amob_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (push_data)
   );

   // The queue lets the front keep accepting while a result waits downstream.
   amob_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (pop_data)
   );

   // The back half updates the bounds and owns the result register.
   amob_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_data  (pop_data),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

`ifndef SYNTHESIS
   // The front never hands a pixel to a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("pixel pushed into a full queue");

   // A flag result without last is followed at once by the margins result.
   a_end_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !rsp_chan.last) |=>
      (rsp_chan.valid && rsp_chan.item_type == amob_pkg::ITEM_BOUNDS))
      else $error("margins result did not follow its last pixel flag");

   // With nothing opaque found, all four margins are zero.
   a_empty_margins: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.item_type == amob_pkg::ITEM_BOUNDS && !rsp_chan.found)
      |-> (rsp_chan.left_margin == '0 && rsp_chan.top_margin == '0 &&
           rsp_chan.right_margin == '0 && rsp_chan.bottom_margin == '0))
      else $error("nonzero margins without an opaque pixel");
`endif

endmodule
